@@ rtl/core/sha256_pkg.sv @@
// shared types, constants and round functions for the sha-256 stream hasher
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [60:0] COUNT_MAX   = {61{1'b1}};
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LEN_START   = 6'd56;

    // command from front to back
    localparam logic [1:0] CMD_BLOCK = 2'd0;  // compress, keep chaining
    localparam logic [1:0] CMD_FINAL = 2'd1;  // compress, emit digest, restart

    typedef struct packed {
        logic [1:0]   cmd;
        logic [511:0] block;
        logic         len_err;
    } sha_cmd_t;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ rtl/core/sha256_front.sv @@
// front end: gathers bytes into blocks, builds padding blocks, issues commands
`timescale 1ns / 1ps

module sha256_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  logic                 has_byte,
    input  logic                 end_of_message,
    input  logic                 valid,
    output logic                 stall,
    output logic                 cmd_valid,
    output sha256_pkg::sha_cmd_t cmd,
    input  logic                 cmd_full
);

    localparam logic [1:0] ST_IN   = 2'd0;
    localparam logic [1:0] ST_PAD1 = 2'd1;  // final block with the length, still to be sent

    logic [1:0]   state_reg, state_next;
    logic [511:0] blk_reg, blk_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  count_reg, count_next;
    logic         ovf_reg, ovf_next;
    logic         pend_reg, pend_next;   // pending command in pend_cmd_reg
    sha256_pkg::sha_cmd_t pend_cmd_reg, pend_cmd_next;

    logic         accept;
    logic [511:0] b;
    logic [5:0]   f;
    logic [60:0]  cnt;
    logic         ov;
    logic [63:0]  bits;
    logic [6:0]   fp;

    assign stall     = (state_reg != ST_IN) || pend_reg;
    assign accept    = valid && !stall;
    assign cmd_valid = pend_reg && !cmd_full;
    assign cmd       = pend_cmd_reg;

    always_comb
    begin
        state_next    = state_reg;
        blk_next      = blk_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pend_next     = pend_reg && cmd_full;
        pend_cmd_next = pend_cmd_reg;
        b    = blk_reg;
        f    = fill_reg;
        cnt  = count_reg;
        ov   = ovf_reg;
        bits = {count_reg, 3'b000};
        fp   = 7'd0;
        if (accept)
        begin
            if (has_byte)
            begin
                b[511 - 8 * f -: 8] = data_byte;
                if (cnt == sha256_pkg::COUNT_MAX)
                    ov = 1'b1;
                else
                    cnt = cnt + 61'd1;
            end
            bits = {cnt, 3'b000};
            fp   = {1'b0, f} + {6'd0, has_byte};
            if (fp == 7'd64)
            begin
                // block full: send it
                pend_next     = 1'b1;
                pend_cmd_next = '{cmd: sha256_pkg::CMD_BLOCK, block: b, len_err: ov};
                fp = 7'd0;
            end
            if (end_of_message)
            begin
                if (fp == 7'd0 && has_byte && f == 6'd63)
                begin
                    // full block is pending, padding block comes next
                    b = '0;
                    b[511 -: 8] = sha256_pkg::PAD_BYTE;
                    b[63:0] = bits;
                    blk_next  = b;
                    state_next = ST_PAD1;
                end
                else
                begin
                    b[511 - 8 * fp[5:0] -: 8] = sha256_pkg::PAD_BYTE;
                    for (int i = 0; i < 64; i++)
                        if (i > fp) b[511 - 8 * i -: 8] = 8'h00;
                    if (fp >= {1'b0, sha256_pkg::LEN_START})
                    begin
                        pend_next     = 1'b1;
                        pend_cmd_next = '{cmd: sha256_pkg::CMD_BLOCK, block: b,
                                          len_err: ov};
                        b = '0;
                        b[63:0] = bits;
                        blk_next   = b;
                        state_next = ST_PAD1;
                    end
                    else
                    begin
                        b[63:0] = bits;
                        pend_next     = 1'b1;
                        pend_cmd_next = '{cmd: sha256_pkg::CMD_FINAL, block: b,
                                          len_err: ov};
                    end
                end
                fill_next  = 6'd0;
                count_next = '0;
                ovf_next   = 1'b0;
                if (state_next == ST_PAD1)
                    ovf_next = ov;  // carried to the final block
            end
            else
            begin
                blk_next   = b;
                fill_next  = fp[5:0];
                count_next = cnt;
                ovf_next   = ov;
            end
        end
        else if (state_reg == ST_PAD1 && !pend_next)
        begin
            pend_next     = 1'b1;
            pend_cmd_next = '{cmd: sha256_pkg::CMD_FINAL, block: blk_reg,
                              len_err: ovf_reg};
            ovf_next   = 1'b0;
            state_next = ST_IN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IN;
            fill_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

@@ rtl/core/sha256_queue.sv @@
// short command queue between front and back
`timescale 1ns / 1ps

module sha256_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  sha256_pkg::sha_cmd_t wr_data,
    output logic                 full,
    output logic                 not_empty,
    input  logic                 rd_en,
    output sha256_pkg::sha_cmd_t rd_data
);

    localparam int unsigned AW = $clog2(sha256_pkg::QUEUE_DEPTH);

    sha256_pkg::sha_cmd_t mem [sha256_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full      = cnt_reg == (AW+1)'(sha256_pkg::QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rd_data   = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + AW'(1);
            if (rd_en) rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

@@ rtl/core/sha256_back.sv @@
// back end: iterative compression, one round a cycle, and digest output
`timescale 1ns / 1ps

module sha256_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_avail,
    input  sha256_pkg::sha_cmd_t cmd,
    output logic                 cmd_take,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index,
    output logic                 last_word,
    output logic                 len_overflow,
    output logic                 valid,
    input  logic                 stall
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]   state_reg;
    logic [5:0]   rnd_reg;
    logic [511:0] w_reg;      // sliding window of 16 schedule words
    logic [255:0] h_reg;      // chaining value
    logic [255:0] v_reg;      // working variables a..h
    logic         fin_reg, err_reg;
    logic [2:0]   idx_reg;

    logic [31:0] a, bb, c, d, e, f, g, hh, wt, t1, t2, s0, s1, wnew, w1, w14;

    always_comb
    begin
        {a, bb, c, d, e, f, g, hh} = v_reg;
        wt   = w_reg[511 -: 32];
        w1   = w_reg[479 -: 32];
        w14  = w_reg[63 -: 32];
        s0   = sha256_pkg::rotr(w1, 7) ^ sha256_pkg::rotr(w1, 18) ^ (w1 >> 3);
        s1   = sha256_pkg::rotr(w14, 17) ^ sha256_pkg::rotr(w14, 19) ^ (w14 >> 10);
        wnew = s1 + w_reg[223 -: 32] + s0 + wt;
        t1   = hh + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
                   ^ sha256_pkg::rotr(e, 25)) + ((e & f) ^ (~e & g))
               + sha256_pkg::round_k(rnd_reg) + wt;
        t2   = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13)
               ^ sha256_pkg::rotr(a, 22)) + ((a & bb) ^ (a & c) ^ (bb & c));
    end

    assign cmd_take     = state_reg == ST_IDLE && cmd_avail;
    assign valid        = state_reg == ST_OUT;
    assign digest_word  = h_reg[255 - 32 * idx_reg -: 32];
    assign word_index   = idx_reg;
    assign last_word    = idx_reg == 3'd7;
    assign len_overflow = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            h_reg     <= sha256_pkg::INIT_HASH;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_avail)
                    begin
                        rnd_reg   <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'(sha256_pkg::ROUNDS - 1))
                        state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    h_reg <= {h_reg[255:224] + a, h_reg[223:192] + bb,
                              h_reg[191:160] + c, h_reg[159:128] + d,
                              h_reg[127:96] + e,  h_reg[95:64] + f,
                              h_reg[63:32] + g,   h_reg[31:0] + hh};
                    idx_reg   <= '0;
                    state_reg <= fin_reg ? ST_OUT : ST_IDLE;
                end
                ST_OUT:
                begin
                    if (!stall)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            h_reg     <= sha256_pkg::INIT_HASH;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            w_reg   <= cmd.block;
            v_reg   <= h_reg;
            fin_reg <= cmd.cmd == sha256_pkg::CMD_FINAL;
            err_reg <= cmd.len_err;
        end
        else if (state_reg == ST_ROUND)
        begin
            w_reg <= {w_reg[479:0], wnew};
            v_reg <= {t1 + t2, a, bb, c, d + t1, e, f, g};
        end
    end

endmodule

@@ rtl/core/sha256_stream_hasher.sv @@
// top level of the sha-256 stream hasher
`timescale 1ns / 1ps

// Byte-stream SHA-256: one byte item per cycle is packed into 64-byte blocks
// by the front end; each full or padding block goes through a 4-entry
// command queue to the back end, which takes a block, runs the 64
// compression rounds one per cycle and adds the chaining value, and then
// presents the eight digest words, word 0 first, one per accepted output
// cycle. Input items are taken at one per cycle while the queue has room,
// except that the front end stalls each time a block is handed to the queue
// and again when the padding needs an extra length block; the sustained
// rate is set by the single-round compression loop. An end-only item
// (has_byte low) finishes a message, so the empty message works. Past
// 2^61-1 bytes the count saturates and every digest word carries len_overflow.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        len_overflow,
    output logic        out_valid,
    input  logic        out_stall
);

    sha256_pkg::sha_cmd_t f_cmd, q_cmd;
    logic f_valid, q_full, q_avail, q_take;

    // byte gathering and padding
    sha256_front u_front (
        .clk(clk), .rst_n(rst_n),
        .data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
        .valid(in_valid), .stall(in_stall),
        .cmd_valid(f_valid), .cmd(f_cmd), .cmd_full(q_full)
    );

    // decoupling queue
    sha256_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_en(f_valid), .wr_data(f_cmd), .full(q_full),
        .not_empty(q_avail), .rd_en(q_take), .rd_data(q_cmd)
    );

    // compression and digest output
    sha256_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_avail(q_avail), .cmd(q_cmd), .cmd_take(q_take),
        .digest_word(digest_word), .word_index(word_index),
        .last_word(last_word), .len_overflow(len_overflow),
        .valid(out_valid), .stall(out_stall)
    );

endmodule
